// ----- sv/sird_pkg.sv -----
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types and constants for the signed integer to radix digit converter.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 32;                   // enough cells for radix 2
  localparam int SYM_W      = 8;
  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CNT_W      = $clog2(2 * NUM_DIGITS);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int DEF_MAX_BASE = 16;

  // Last convert cycle: the final bit reaches the top cell after the skew.
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * NUM_DIGITS - 2);

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [LEN_W-1:0] MIN_RADIX  = 5'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Broadcast control for the digit cells
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- sv/signed_integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Converts a signed 32-bit value to its digit symbols in a configured radix.
// ----------------------------------------------------------------------------
// All 32 magnitude bits are clocked MSB first through the carry skew of the 32-cell digit
//   row; a minus sign strobes next if the value is negative, then digits follow once leading
//   zeros shift out. Busy holds through convert, sign and readout, so no new item is
//   taken until the last digit has been read out.
// A start with an invalid alphabet is ignored: it gives no symbols and busy stays low.
// Results cannot be stalled; each strobe lasts one cycle.
// Reset: synchronous; config registers and strobe clear to 0 and the block returns to idle.
module signed_integer_to_radix_digits
  import sird_pkg::*;
#(
  parameter int MAX_BASE = DEF_MAX_BASE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_W-1:0]    value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         strobe,
  output logic [SYM_W-1:0]             symbol,
  output logic                         last
);

  localparam int DIGIT_W = $clog2(MAX_BASE);
  localparam int SUM_W   = DIGIT_W + 1;

  state_t state, state_next;

  logic [LEN_W-1:0]      base_length;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;

  logic [SYM_W-1:0]   alphabet [SLOTS];
  logic               alpha_ok;
  logic               accept;

  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] raw;
  logic               neg;
  logic               started;
  logic [CNT_W-1:0]   cnt;
  logic [REM_W-1:0]   rem;

  cell_ctl_t          cell_ctl;
  logic               feed_act;
  logic [DIGIT_W-1:0] top_digit;
  logic               emit;
  logic [SYM_W-1:0]   emit_sym;
  logic               emit_last;
  logic               rem_one;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_LENGTH:  base_length  <= cfg_data[LEN_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Alphabet check: length in range, no sign characters, no repeats
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      if (k < SLOTS / 2) begin
        alphabet[k] = symbols_low[k*SYM_W +: SYM_W];
      end else begin
        alphabet[k] = symbols_high[(k - SLOTS/2)*SYM_W +: SYM_W];
      end
    end
    alpha_ok = (base_length >= MIN_RADIX) && (base_length <= LEN_W'(MAX_BASE));
    for (int a = 0; a < SLOTS; a++) begin
      if (LEN_W'(a) < base_length) begin
        if (alphabet[a] == CHAR_PLUS || alphabet[a] == CHAR_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int b = a + 1; b < SLOTS; b++) begin
          if (LEN_W'(b) < base_length && alphabet[b] == alphabet[a]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy && alpha_ok;
  assign raw     = value;
  assign rem_one = (rem == REM_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_CONV;
      ST_CONV:   if (cnt == CONV_LAST) state_next = neg ? ST_SIGN : ST_DIGITS;
      ST_SIGN:   state_next = ST_DIGITS;
      ST_DIGITS: if (rem_one) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cell_ctl  = '0;
    feed_act  = 1'b0;
    emit      = 1'b0;
    emit_sym  = alphabet[SLOT_W'(top_digit)];
    emit_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cell_ctl.clear = accept;
      end
      ST_CONV: begin
        feed_act = (cnt < CNT_W'(NUM_DIGITS));
      end
      ST_SIGN: begin
        emit     = 1'b1;
        emit_sym = CHAR_MINUS;
      end
      ST_DIGITS: begin
        // drop leading zeros, but always keep the units digit
        cell_ctl.shift = 1'b1;
        emit      = (top_digit != '0) || started || rem_one;
        emit_last = rem_one;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag     <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      neg     <= raw[VALUE_W-1];
      cnt     <= '0;
      rem     <= REM_W'(NUM_DIGITS);
      started <= 1'b0;
    end else if (state == ST_CONV) begin
      mag <= {mag[VALUE_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end else if (state == ST_DIGITS) begin
      rem     <= rem - REM_W'(1);
      started <= started | emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    symbol <= emit_sym;
    last   <= emit_last;
  end

  sird_chain #(.MAX_BASE(MAX_BASE)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cell_ctl),
    .radix     (base_length[SUM_W-1:0]),
    .feed_bit  (mag[VALUE_W-1]),
    .feed_act  (feed_act),
    .top_digit (top_digit)
  );

  // Checks
  a_strobe_follows_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("symbol strobed without an item in flight");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("sequencer still busy after the final symbol");

  a_quiet_in_convert: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_CONV) |-> !strobe)
    else $error("symbol strobed during conversion");

  a_bad_alphabet_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !alpha_ok) |=> !busy)
    else $error("item with invalid alphabet started a conversion");

endmodule

// ----- sv/sird_cell.sv -----
// ----------------------------------------------------------------------------
// sird_cell
// One radix digit cell: doubles its digit plus the carry from below, reduces
// modulo the radix and hands the carry up; shifts digits up during readout.
// ----------------------------------------------------------------------------
module sird_cell
  import sird_pkg::*;
#(
  parameter int MAX_BASE = DEF_MAX_BASE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctl_t                     ctl,
  input  logic [$clog2(MAX_BASE):0]     radix,
  input  logic [$clog2(MAX_BASE)-1:0]   digit_in,
  input  logic                          carry_in,
  input  logic                          act_in,
  output logic [$clog2(MAX_BASE)-1:0]   digit,
  output logic                          carry_out,
  output logic                          act_out
);

  localparam int DIGIT_W = $clog2(MAX_BASE);
  localparam int SUM_W   = DIGIT_W + 1;

  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   diff;
  logic               ge;
  logic [DIGIT_W-1:0] digit_next;

  assign sum        = {digit, carry_in};
  assign diff       = sum - radix;
  assign ge         = (sum >= radix);
  assign digit_next = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.shift) begin
      digit <= digit_in;
    end else if (act_in) begin
      digit <= digit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear || ctl.shift) begin
      carry_out <= 1'b0;
      act_out   <= 1'b0;
    end else begin
      carry_out <= act_in & ge;
      act_out   <= act_in;
    end
  end

endmodule

// ----- sv/sird_chain.sv -----
// ----------------------------------------------------------------------------
// sird_chain
// Row of digit cells, least significant at the bottom. Magnitude bits enter
// the bottom cell and carries ripple up one cell per cycle.
// ----------------------------------------------------------------------------
module sird_chain
  import sird_pkg::*;
#(
  parameter int MAX_BASE = DEF_MAX_BASE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctl_t                     ctl,
  input  logic [$clog2(MAX_BASE):0]     radix,
  input  logic                          feed_bit,
  input  logic                          feed_act,
  output logic [$clog2(MAX_BASE)-1:0]   top_digit
);

  localparam int DIGIT_W = $clog2(MAX_BASE);

  logic [DIGIT_W-1:0] digit_w [NUM_DIGITS];
  logic               carry_w [NUM_DIGITS];
  logic               act_w   [NUM_DIGITS];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      sird_cell #(.MAX_BASE(MAX_BASE)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .radix     (radix),
        .digit_in  ('0),
        .carry_in  (feed_bit),
        .act_in    (feed_act),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .act_out   (act_w[i])
      );
    end else begin : g_upper
      sird_cell #(.MAX_BASE(MAX_BASE)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .radix     (radix),
        .digit_in  (digit_w[i-1]),
        .carry_in  (carry_w[i-1]),
        .act_in    (act_w[i-1]),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .act_out   (act_w[i])
      );
    end
  end

  assign top_digit = digit_w[NUM_DIGITS-1];

endmodule
